/* hw/rtl/qdec_pkg.sv */
// Shared types, codes and constants of the quadrature decoder.
package qdec_pkg;

  // item kinds on the input tuser
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_UNKNOWN = 2'd0;
  localparam logic [1:0] DIR_CW      = 2'd1;
  localparam logic [1:0] DIR_CCW     = 2'd2;

  // step codes from the transition table
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNTS_PER_REV  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_TIMEOUT_US = 1'd1;

  localparam logic [15:0] CPR_RESET  = 16'd2048;
  localparam logic [31:0] IDLE_RESET = 32'd500000;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  // 60e6 * 256 = 234375 * 2^16
  localparam logic [17:0] SPEED_K     = 18'd234375;
  localparam int unsigned SPEED_SHIFT = 16;
  localparam int unsigned DIV_W       = 48;
  localparam int unsigned QUO_W       = 32;
  localparam int unsigned CNT_W       = 5;
  localparam logic [31:0] SAT_MAG     = 32'h8000_0000;
  localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic finish;
    logic load_out;
  } qdec_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       primed;
    logic       div_zero;
  } qdec_sts_t;

  // x4 decode of previous and current AB pair, A in the high bit
  function automatic logic [1:0] qdec_step(input logic [1:0] prev, input logic [1:0] cur);
    logic [1:0] s;
    case ({prev, cur})
      4'b0001: s = STEP_DOWN;
      4'b0010: s = STEP_UP;
      4'b0100: s = STEP_UP;
      4'b0111: s = STEP_DOWN;
      4'b1000: s = STEP_DOWN;
      4'b1011: s = STEP_UP;
      4'b1101: s = STEP_UP;
      4'b1110: s = STEP_DOWN;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/qdec_ctrl.sv */
// Sequencer of the quadrature decoder: item flow, multiply and divide steps.
module qdec_ctrl #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  qdec_pkg::qdec_sts_t sts,
  output qdec_pkg::qdec_cmd_t cmd
);
  import qdec_pkg::*;

  localparam int unsigned NCH = (POSITION_WIDTH + 31) / 32;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DINIT, S_DIV, S_FINISH, S_WRITE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_tready_r, in_tready_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.kind == KIND_TICK && sts.primed) begin
          if (sts.div_zero) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_MUL;
            cnt_nxt   = CNT_W'(NCH - 1);
          end
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DINIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNT_W'(QUO_W - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_WRITE;
      end
      S_WRITE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.load_out   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_tready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      in_tready_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

/* hw/rtl/qdec_dp.sv */
// Datapath of the quadrature decoder: counter state, speed multiply and divide.
module qdec_dp #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [qdec_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [qdec_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [1:0]                            in_tuser,
  input  logic [qdec_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic [qdec_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  qdec_pkg::qdec_cmd_t                    cmd,
  output qdec_pkg::qdec_sts_t                    sts
);
  import qdec_pkg::*;

  localparam int unsigned PW  = POSITION_WIDTH;
  localparam int unsigned NCH = (PW + 31) / 32;
  localparam int unsigned MW  = NCH * 32;
  localparam int unsigned PRW = PW + 18;
  localparam int unsigned HW  = PRW - SPEED_SHIFT;
  localparam int unsigned CW  = (HW > DIV_W) ? HW : DIV_W;
  localparam int unsigned XW  = (PW > 32) ? PW : 32;

  // configuration
  logic [15:0] cpr_r;
  logic [31:0] idle_r;

  // decoder state
  logic [1:0]    prev_ab_r;
  logic [PW-1:0] pos_r;
  logic [1:0]    dir_r;
  logic [31:0]   pulse_r;
  logic [31:0]   speed_r;
  logic [31:0]   calc_time_r;
  logic [PW-1:0] calc_pos_r;
  logic          primed_r;

  // item and work registers
  logic [1:0]       kind_r;
  logic [1:0]       ab_r;
  logic [31:0]      now_r;
  logic             calc_r;
  logic             neg_r;
  logic [MW-1:0]    mag_r;
  logic [DIV_W-1:0] d_r;
  logic [PRW-1:0]   prod_r;
  logic [DIV_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [31:0]      sh_r;
  logic             ovf_r;

  // output register
  logic [31:0] o_pos_r, o_speed_r, o_pulse_r;
  logic [1:0]  o_dir_r;

  logic [31:0]      dt;
  logic [PW-1:0]    diff;
  logic [DIV_W-1:0] d_prod;
  logic [49:0]      mul_w;
  logic [HW-1:0]    hi;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [31:0]      cap, spd, spd_new;
  logic [1:0]       step;
  logic [XW-1:0]    pos_ext;

  assign dt      = now_r - calc_time_r;
  assign diff    = pos_r - calc_pos_r;
  assign d_prod  = DIV_W'(cpr_r) * DIV_W'(dt);
  assign mul_w   = 50'(mag_r[MW-1 -: 32]) * 50'(SPEED_K);
  assign hi      = prod_r[PRW-1:SPEED_SHIFT];
  assign trial   = {rem_r, sh_r[31]};
  assign ge      = (trial >= {1'b0, d_r});
  assign step    = qdec_step(prev_ab_r, ab_r);
  assign pos_ext = XW'(pos_r);

  // saturate magnitude at 2^31, then apply sign; positive results clamp at 2^31-1
  always_comb begin
    cap     = (ovf_r || (quo_r > SAT_MAG)) ? SAT_MAG : quo_r;
    spd     = neg_r ? (32'h0 - cap) : (cap[31] ? SAT_POS : cap);
    spd_new = calc_r ? spd : speed_r;
  end

  assign sts.kind     = kind_r;
  assign sts.primed   = primed_r;
  assign sts.div_zero = (dt == 32'h0) || (cpr_r == 16'h0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r       <= CPR_RESET;
      idle_r      <= IDLE_RESET;
      prev_ab_r   <= '0;
      pos_r       <= '0;
      dir_r       <= DIR_UNKNOWN;
      pulse_r     <= '0;
      speed_r     <= '0;
      calc_time_r <= '0;
      calc_pos_r  <= '0;
      primed_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_COUNTS_PER_REV:  cpr_r  <= cfg_wdata[15:0];
          CFG_IDLE_TIMEOUT_US: idle_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (kind_r)
          KIND_SAMPLE: begin
            if (step == STEP_UP) begin
              pos_r   <= pos_r + PW'(1);
              dir_r   <= DIR_CW;
              pulse_r <= now_r;
            end else if (step == STEP_DOWN) begin
              pos_r   <= pos_r - PW'(1);
              dir_r   <= DIR_CCW;
              pulse_r <= now_r;
            end
            prev_ab_r <= ab_r;
          end
          KIND_TICK: begin
            if (!primed_r) begin
              primed_r    <= 1'b1;
              calc_time_r <= now_r;
              calc_pos_r  <= pos_r;
            end
          end
          KIND_CLEAR: begin
            pos_r   <= '0;
            speed_r <= '0;
            dir_r   <= DIR_UNKNOWN;
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if ((now_r - pulse_r) > idle_r) begin
          speed_r <= '0;
          dir_r   <= DIR_UNKNOWN;
        end else begin
          speed_r <= spd_new;
        end
        calc_time_r <= now_r;
        calc_pos_r  <= pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_tuser;
      ab_r   <= {in_tdata[0], in_tdata[1]};
      now_r  <= in_tdata[33:2];
    end
    if (cmd.exec) begin
      calc_r <= !sts.div_zero;
      neg_r  <= diff[PW-1];
      mag_r  <= MW'(diff[PW-1] ? (PW'(0) - diff) : diff);
      d_r    <= d_prod;
      prod_r <= '0;
    end
    if (cmd.mul_step) begin
      prod_r <= {prod_r[PRW-33:0], 32'h0} + PRW'(mul_w);
      mag_r  <= mag_r << 32;
    end
    if (cmd.div_init) begin
      ovf_r <= (CW'(hi) >= CW'(d_r));
      rem_r <= DIV_W'(hi);
      sh_r  <= {prod_r[SPEED_SHIFT-1:0], 16'h0};
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? DIV_W'(trial - {1'b0, d_r}) : trial[DIV_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      sh_r  <= sh_r << 1;
    end
    if (cmd.load_out) begin
      o_pos_r   <= pos_ext[31:0];
      o_speed_r <= speed_r;
      o_dir_r   <= dir_r;
      o_pulse_r <= pulse_r;
    end
  end

  assign out_tdata = {6'h0, o_pulse_r, o_dir_r, o_speed_r, o_pos_r};

endmodule

/* hw/rtl/quadrature_decoder_with_speed_top.sv */
// Top level of the x4 quadrature decoder with speed measurement.
// Sequence: a pin sample, clear or priming tick passes S_EXEC and S_WRITE; a speed tick also
//   runs the 32x18 multiply steps, S_DINIT, the 32-step restoring divider and S_FINISH, or
//   skips to S_FINISH when elapsed time or counts_per_rev is zero. One item at a time: the next
//   beat is taken after write-back, which waits while an earlier result is still held.
// Reset: synchronous, active low; clears position, speed, direction, times and the
//   priming flag, and loads counts_per_rev = 2048 and idle_timeout_us = 500000.
module quadrature_decoder_with_speed_top #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [qdec_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [qdec_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input beats
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [qdec_pkg::IN_TDATA_W-1:0]    in_tdata,  // pin_a, pin_b, now_us[31:0], pad
  input  logic [1:0]                        in_tuser,  // kind
  // result beats
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [qdec_pkg::OUT_TDATA_W-1:0]   out_tdata  // position, speed_rpm_q8, direction,
                                                      // last_pulse_us, pad
);
  import qdec_pkg::*;

  qdec_cmd_t cmd;
  qdec_sts_t sts;

  // sequencer: walks each item through execute and write-back, a speed tick also through multiply, divide and finish
  qdec_ctrl #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: decoder state, config registers, speed arithmetic, result register
  qdec_dp #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .out_tdata(out_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

  // an accepted beat closes the input until its result is written back
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still open after accepting a beat");

  // at most one datapath operation per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.mul_step, cmd.div_init, cmd.div_step, cmd.finish, cmd.load_out}))
    else $error("overlapping datapath commands");

  // a write-back always presents a result
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result loaded but not presented");

  // a taken result with nothing new behind it leaves the output empty
  a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !cmd.load_out) |=> !out_tvalid)
    else $error("result repeated after being taken");

endmodule
